@@ sv/csm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csm_pkg: shared widths and codes for the CSR sparse matrix-vector block
// Field widths, operation codes and register indexes used by the channel
// interfaces and the datapath.
// ----------------------------------------------------------------------------
package csm_pkg;

  // Default depth of the dense vector store
  localparam int unsigned VEC_DEPTH_DEF = 1024;

  // Payload field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 1;

  // Operation codes carried in func
  localparam logic [FUNC_W-1:0] FUNC_VEC_WR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NONZERO = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROW_END = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] VECTOR_LENGTH_RST = 11'd1024;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST     = 11'd1024;

endpackage
`default_nettype wire

@@ sv/csm_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csm_cfg_if: configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface csm_cfg_if;
  import csm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);

endinterface
`default_nettype wire

@@ sv/csm_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csm_in_if: input item channel
// Carries vector writes, matrix nonzeros and empty-row closes.
// ----------------------------------------------------------------------------
interface csm_in_if;
  import csm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [IDX_W-1:0]        vector_index;
  logic signed [VAL_W-1:0] vector_value;
  logic signed [VAL_W-1:0] entry_value;
  logic [IDX_W-1:0]        entry_column;
  logic                    row_end;

  modport source (output valid, output func, output vector_index, output vector_value,
                  output entry_value, output entry_column, output row_end, input ready);
  modport sink   (input valid, input func, input vector_index, input vector_value,
                  input entry_value, input entry_column, input row_end, output ready);

endinterface
`default_nettype wire

@@ sv/csm_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csm_out_if: row result channel
// One beat per finished row: sum, index and error flags.
// ----------------------------------------------------------------------------
interface csm_out_if;
  import csm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        row_index;
  logic signed [ACC_W-1:0] row_value;
  logic                    dimension_error;
  logic                    column_error;
  logic                    last_row;

  modport source (output valid, output row_index, output row_value,
                  output dimension_error, output column_error, output last_row,
                  input ready);
  modport sink   (input valid, input row_index, input row_value,
                  input dimension_error, input column_error, input last_row,
                  output ready);

endinterface
`default_nettype wire

@@ sv/csr_sparse_matvec_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Row path: vector store read, multiply register, output register accumulate.
// Throughput: one input beat per cycle unless a row close is blocked at a full
//   output register; the vector store has one write and one read port and the
//   accumulator is a single register updated as each beat leaves stage 2.
// Reset: control, accumulator, row counter and output valid clear at once; the
//   config registers go to 1024; the vector store holds garbage until written.
// ----------------------------------------------------------------------------
// csr_sparse_matvec_top: CSR sparse matrix times dense vector
// Loads a Q16.16 vector into an internal RAM, then multiplies streamed
// nonzeros by their vector element and accumulates each row in saturating
// Q32.32, emitting one result beat per row.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_top #(
  parameter int unsigned VEC_DEPTH = csm_pkg::VEC_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  csm_cfg_if.sink    cfg_i,
  csm_in_if.sink     in_i,
  csm_out_if.source  out_o
);
  import csm_pkg::*;

  // Store address width and a compare width that holds the depth itself
  localparam int unsigned AW = $clog2(VEC_DEPTH);
  localparam int unsigned XW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(VEC_DEPTH);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Configuration registers
  logic [CFG_W-1:0] vec_len_q, row_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_len_q <= VECTOR_LENGTH_RST;
      row_cnt_q <= ROW_COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_VECTOR_LENGTH: vec_len_q <= cfg_i.data;
        REG_ROW_COUNT:     row_cnt_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // Pipeline control
  logic adv;
  logic in_fire;

  // stage 1: store read in flight
  logic                    v1_q, mac1_q, fault1_q, fin1_q;
  logic signed [VAL_W-1:0] ent1_q;
  logic signed [VAL_W-1:0] rd1_q;
  // stage 2: product registered
  logic                    v2_q, mac2_q, fault2_q, fin2_q;
  logic signed [ACC_W-1:0] prod2_q;
  // row state
  logic signed [ACC_W-1:0] acc_q;
  logic                    fault_q;
  logic [IDX_W-1:0]        row_q;
  // output register
  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_row_q;
  logic signed [ACC_W-1:0] out_val_q;
  logic                    out_dim_q, out_col_q, out_last_q;

  // Only a row close with the output register full and not draining stalls
  assign adv     = !(v2_q && fin2_q && out_valid_q && !out_o.ready);
  assign in_fire = in_i.valid && adv;
  assign in_i.ready = adv;

  // Stage 0 decode
  logic [XW-1:0] wr_idx_x, col_x;
  logic          is_wr, is_nz, is_close, col_ok;

  always_comb begin
    wr_idx_x = XW'(in_i.vector_index);
    col_x    = XW'(in_i.entry_column);
    is_wr    = (in_i.func == FUNC_VEC_WR) && (wr_idx_x < DEPTH_X);
    is_nz    = (in_i.func == FUNC_NONZERO);
    is_close = (in_i.func == FUNC_ROW_END) || (is_nz && in_i.row_end);
    col_ok   = (CFG_W'(in_i.entry_column) < vec_len_q) && (col_x < DEPTH_X);
  end

  // Vector store: one write port, one registered read port
  logic [VAL_W-1:0] vec_mem_q [VEC_DEPTH];

  always_ff @(posedge clk_i) begin
    if (in_fire && is_wr) begin
      vec_mem_q[wr_idx_x[AW-1:0]] <= in_i.vector_value;
    end
    if (adv) begin
      rd1_q  <= vec_mem_q[col_x[AW-1:0]];
      ent1_q <= in_i.entry_value;
    end
  end

  // Multiply stage payload
  logic signed [ACC_W-1:0] prod_d;
  assign prod_d = ent1_q * rd1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod2_q <= prod_d;
    end
  end

  // Saturating accumulate
  logic signed [ACC_W:0]   sum_x;
  logic signed [ACC_W-1:0] acc_d;
  logic                    fault_d;
  logic                    last_d;
  logic [IDX_W-1:0]        row_d;
  logic                    consume;

  always_comb begin
    sum_x = {acc_q[ACC_W-1], acc_q} + (mac2_q ? {prod2_q[ACC_W-1], prod2_q} : '0);
    if (sum_x[ACC_W] != sum_x[ACC_W-1]) begin
      acc_d = sum_x[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_d = sum_x[ACC_W-1:0];
    end
    fault_d = fault_q || fault2_q;
    last_d  = ({1'b0, row_q} + CFG_W'(1)) == row_cnt_q;
    row_d   = last_d ? '0 : row_q + IDX_W'(1);
    consume = adv && v2_q;
  end

  // Control and row state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      mac1_q      <= 1'b0;
      fault1_q    <= 1'b0;
      fin1_q      <= 1'b0;
      v2_q        <= 1'b0;
      mac2_q      <= 1'b0;
      fault2_q    <= 1'b0;
      fin2_q      <= 1'b0;
      acc_q       <= '0;
      fault_q     <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v1_q     <= in_fire && (is_nz || is_close);
        mac1_q   <= is_nz && col_ok;
        fault1_q <= is_nz && !col_ok;
        fin1_q   <= is_close;
        v2_q     <= v1_q;
        mac2_q   <= mac1_q;
        fault2_q <= fault1_q;
        fin2_q   <= fin1_q;
      end
      if (consume && fin2_q) begin
        acc_q       <= '0;
        fault_q     <= 1'b0;
        row_q       <= row_d;
        out_valid_q <= 1'b1;
      end else begin
        if (consume) begin
          acc_q   <= acc_d;
          fault_q <= fault_d;
        end
        if (out_o.ready) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (consume && fin2_q) begin
      out_row_q  <= row_q;
      out_val_q  <= acc_d;
      out_dim_q  <= row_cnt_q != vec_len_q;
      out_col_q  <= fault_d;
      out_last_q <= last_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.row_index       = out_row_q;
  assign out_o.row_value       = out_val_q;
  assign out_o.dimension_error = out_dim_q;
  assign out_o.column_error    = out_col_q;
  assign out_o.last_row        = out_last_q;

`ifndef SYNTHESIS
  // Input stalls only behind a row close blocked at a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v2_q && fin2_q && out_valid_q))
    else $error("input stalled without a blocked row close");

  // Closing a row clears the accumulator and fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && fin2_q) |=> (acc_q == '0 && !fault_q && out_valid_q))
    else $error("row state not cleared after row close");

  // The final row sends the row counter back to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && fin2_q && last_d) |=> (row_q == '0))
    else $error("row counter not reset after last row");

  // A column fault inside an open row is remembered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && fault2_q && !fin2_q) |=> fault_q)
    else $error("column fault lost");
`endif

endmodule
`default_nettype wire
